>>> sv/gdd_pkg.sv
// Shared types, constants and calendar helper functions for the day-difference block.
`timescale 1ns / 1ps

package gdd_pkg;

   localparam int DayWidth   = 5;
   localparam int MonthWidth = 4;
   localparam int YearWidth  = 14;
   localparam int CountWidth = 22;
   localparam int DoyWidth   = 9;
   localparam int Q100Width  = 8;
   localparam int BaseWidth  = 23;

   localparam logic [YearWidth-1:0]  YearMax    = 14'd9999;
   localparam logic [12:0]           Recip100   = 13'd5243;
   localparam int                    Recip100Sh = 19;
   localparam logic [MonthWidth-1:0] MonthJan   = 4'd1;
   localparam logic [MonthWidth-1:0] MonthFeb   = 4'd2;
   localparam logic [MonthWidth-1:0] MonthDec   = 4'd12;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   typedef struct packed {
      logic [CountWidth-1:0] serial;
      logic                  ok;
   } date_serial_type;

   // days in a month; zero for a month code outside January..December
   function automatic logic [DayWidth-1:0] days_in_month(input logic [MonthWidth-1:0] m,
                                                         input logic leap);
      logic [DayWidth-1:0] lim;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    lim = 5'd30;
         4'd2:                                       lim = leap ? 5'd29 : 5'd28;
         default:                                    lim = 5'd0;
      endcase
      return lim;
   endfunction

   // day offset of the month's first day in a year that starts in March
   function automatic logic [DoyWidth-1:0] month_offset(input logic [MonthWidth-1:0] m);
      logic [DoyWidth-1:0] off;
      case (m)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

>>> sv/gdd_date_unit.sv
// Three-stage pipeline that checks one date and turns it into a serial day number.
`timescale 1ns / 1ps

module gdd_date_unit
   import gdd_pkg::*;
(
   input  logic                  clock,
   input  stage_en_type          en,
   input  logic [DayWidth-1:0]   day,
   input  logic [MonthWidth-1:0] month,
   input  logic [YearWidth-1:0]  year,
   output date_serial_type       result
);

   logic [DayWidth-1:0]   d1_ff;
   logic [MonthWidth-1:0] m1_ff;
   logic [YearWidth-1:0]  y1_ff;
   logic [Q100Width-1:0]  q100y_ff, q100y_in;
   logic [YearWidth+12:0] q_prod;

   logic [BaseWidth-1:0]  base_ff, base_in;
   logic [Q100Width-1:0]  q100yy_ff, q100yy_in;
   logic                  ok2_ff, ok2_in;

   logic [CountWidth-1:0] serial_ff, serial_in;
   logic                  ok3_ff;

   logic [YearWidth-1:0]  rem_full;
   logic [6:0]            rem100;
   logic                  leap;
   logic                  jan_feb;
   logic                  month_ok;
   logic [YearWidth-1:0]  yy;
   logic [DoyWidth-1:0]   doy;
   logic [DayWidth-1:0]   lim;

   // stage 1: year / 100 by reciprocal multiply
   assign q_prod   = {13'd0, year} * {14'd0, Recip100};
   assign q100y_in = Q100Width'(q_prod >> Recip100Sh);

   // stage 2: validity, March-based year and month, partial serial number
   always_comb begin
      rem_full  = y1_ff - YearWidth'(q100y_ff) * YearWidth'(100);
      rem100    = rem_full[6:0];
      leap      = ((y1_ff[1:0] == 2'd0) && (rem100 != 7'd0)) ||
                  ((rem100 == 7'd0) && (q100y_ff[1:0] == 2'd0));
      lim       = days_in_month(m1_ff, leap);
      month_ok  = m1_ff inside {[MonthJan:MonthDec]};
      ok2_in    = (y1_ff != '0) && (y1_ff <= YearMax) && month_ok &&
                  (d1_ff != '0) && (d1_ff <= lim);
      jan_feb   = (m1_ff == MonthJan) || (m1_ff == MonthFeb);
      yy        = jan_feb ? y1_ff - YearWidth'(1) : y1_ff;
      q100yy_in = (jan_feb && (rem100 == 7'd0)) ? q100y_ff - Q100Width'(1) : q100y_ff;
      doy       = month_offset(m1_ff) + DoyWidth'(d1_ff) - DoyWidth'(1);
      base_in   = BaseWidth'(yy) * BaseWidth'(365) + BaseWidth'(yy >> 2) + BaseWidth'(doy);
   end

   // stage 3: century corrections
   assign serial_in = CountWidth'(base_ff - BaseWidth'(q100yy_ff)
                                  + BaseWidth'(q100yy_ff >> 2));

   always_ff @(posedge clock) begin
      if (en.s1) begin
         d1_ff    <= day;
         m1_ff    <= month;
         y1_ff    <= year;
         q100y_ff <= q100y_in;
      end
      if (en.s2) begin
         base_ff   <= base_in;
         q100yy_ff <= q100yy_in;
         ok2_ff    <= ok2_in;
      end
      if (en.s3) begin
         serial_ff <= serial_in;
         ok3_ff    <= ok2_ff;
      end
   end

   assign result.serial = serial_ff;
   assign result.ok     = ok3_ff;

endmodule

>>> sv/gregorian_day_difference_top.sv
// Top level: Gregorian day difference between two dates, four-stage pipeline.
//
// Usage:
//   req_* channel carries a start date and an end date (day, month, year).
//   A transfer happens at a rising edge with valid high and stall low.
//   rsp_* channel returns rsp_day_count and rsp_date_error, one per request,
//   in order. A bad date in either input gives date_error 1 and count 0.
//   csr_wr_en / csr_wr_data write include_end_day (adds one to each count without a date error);
//   write it only while no request is in flight.
// Timing:
//   A request passes the three registered date stages and then the registered
//   compare/subtract stage before rsp_valid. Throughput is one transfer per
//   cycle while rsp_stall is low; each stage holds one item.
// Reset (synchronous, active high) empties the pipeline and clears
//   include_end_day. When rsp_stall is high the result holds; stages behind
//   it keep filling bubbles, and req_stall rises once all four are full.
`timescale 1ns / 1ps

module gregorian_day_difference_top
   import gdd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DayWidth-1:0]   req_start_day,
   input  logic [MonthWidth-1:0] req_start_month,
   input  logic [YearWidth-1:0]  req_start_year,
   input  logic [DayWidth-1:0]   req_end_day,
   input  logic [MonthWidth-1:0] req_end_month,
   input  logic [YearWidth-1:0]  req_end_year,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CountWidth-1:0] rsp_day_count,
   output logic                  rsp_date_error,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   logic [3:0]            valid_ff, valid_in;
   logic [3:0]            ready;
   stage_en_type          en;
   date_serial_type       start_res, end_res;
   logic                  include_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  err_ff, err_in;

   // a stage loads when empty or when the stage after it moves on
   assign ready[3] = !valid_ff[3] || !rsp_stall;
   assign ready[2] = !valid_ff[2] || ready[3];
   assign ready[1] = !valid_ff[1] || ready[2];
   assign ready[0] = !valid_ff[0] || ready[1];

   assign en.s1 = ready[0];
   assign en.s2 = ready[1];
   assign en.s3 = ready[2];

   assign valid_in = {valid_ff[2:0], req_valid};

   gdd_date_unit u_start (
      .clock  (clock),
      .en     (en),
      .day    (req_start_day),
      .month  (req_start_month),
      .year   (req_start_year),
      .result (start_res)
   );

   gdd_date_unit u_end (
      .clock  (clock),
      .en     (en),
      .day    (req_end_day),
      .month  (req_end_month),
      .year   (req_end_year),
      .result (end_res)
   );

   always_comb begin
      if (!(start_res.ok && end_res.ok)) begin
         err_in   = 1'b1;
         count_in = '0;
      end else begin
         err_in   = 1'b0;
         count_in = (start_res.serial < end_res.serial) ?
                    end_res.serial - start_res.serial : '0;
         count_in = count_in + CountWidth'(include_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         include_ff <= 1'b0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
         if (csr_wr_en) begin
            include_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   assign req_stall      = !ready[0];
   assign rsp_valid      = valid_ff[3];
   assign rsp_day_count  = count_ff;
   assign rsp_date_error = err_ff;

endmodule
